// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the ranker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg
// Types and constants shared by the top-k ranker modules.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int unsigned SCORE_W     = 16;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned RANK_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // One incoming request
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } item_t;

  // One emitted table entry
  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } result_t;

  // Back-end sequencer states
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } back_state_t;

endpackage

// ===== rtl/tks_fifo.sv =====
// ----------------------------------------------------------------------------
// tks_fifo
// Small register queue with push/full and pop/empty, first-word fall-through.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tks_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] wptr_next;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W-1:0] rptr_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = store[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers with explicit wrap
  always_comb begin
    wptr_next  = (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
    rptr_next  = (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr_next;
      end
      if (do_pop) begin
        rptr <= rptr_next;
      end
      count <= count_next;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= wdata;
    end
  end

  `ASSERT_NEVER(a_count_range, clk, rst, count > CNT_W'(DEPTH), "fifo count above depth")
  `ASSERT_CLK(a_push_only, clk, rst, (do_push && !do_pop) |=> (count == $past(count) + CNT_W'(1)), "fifo count missed a push")
  `ASSERT_CLK(a_pop_only, clk, rst, (do_pop && !do_push) |=> (count == $past(count) - CNT_W'(1)), "fifo count missed a pop")

endmodule

// ===== rtl/tks_table.sv =====
// ----------------------------------------------------------------------------
// tks_table
// Back end: sorted table of cells; each request is inserted, then the whole
// list is emitted one entry per cycle into the result queue while it is not full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tks_table
  import tks_pkg::*;
#(
  parameter int unsigned DEPTH = 5
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   in_item,
  input  logic    in_empty,
  output logic    in_pop,
  output result_t res,
  input  logic    out_full,
  output logic    out_push
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [SCORE_W-1:0] slot_score [DEPTH];
  logic [TAG_W-1:0]   slot_tag   [DEPTH];
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   fill_next;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   k_next;
  logic [DEPTH-1:0]   ge;
  logic               at_last;
  back_state_t        state;
  back_state_t        state_next;

  // Mark cells at or past the insertion point (empty cells count as past)
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign ge[i] = (fill <= CNT_W'(i)) || (in_item.score < slot_score[i]);
  end

  // Insert the new entry and shift later entries down by one
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (in_pop && ge[0]) begin
          slot_score[0] <= in_item.score;
          slot_tag[0]   <= in_item.tag;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (in_pop && ge[i-1]) begin
          slot_score[i] <= slot_score[i-1];
          slot_tag[i]   <= slot_tag[i-1];
        end else if (in_pop && ge[i]) begin
          slot_score[i] <= in_item.score;
          slot_tag[i]   <= in_item.tag;
        end
      end
    end
  end

  assign at_last = (k == fill - CNT_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (!in_empty) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_full && at_last) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs and counters
  always_comb begin
    in_pop    = 1'b0;
    out_push  = 1'b0;
    fill_next = fill;
    k_next    = k;
    case (state)
      ST_LOAD: begin
        in_pop = !in_empty;
        k_next = '0;
        if (!in_empty && (fill != CNT_W'(DEPTH))) begin
          fill_next = fill + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        out_push = !out_full;
        if (!out_full) begin
          k_next = k + CNT_W'(1);
        end
      end
      default: begin
        in_pop = 1'b0;
      end
    endcase
  end

  // Present the entry at the emit counter
  always_comb begin
    res.rank  = RANK_W'(k);
    res.score = slot_score[k[IDX_W-1:0]];
    res.tag   = slot_tag[k[IDX_W-1:0]];
    res.last  = at_last;
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fill  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      k     <= k_next;
    end
  end

  `ASSERT_NEVER(a_fill_range, clk, rst, fill > CNT_W'(DEPTH), "fill count above table depth")
  `ASSERT_CLK(a_emit_range, clk, rst, (state == ST_EMIT) |-> (k < fill), "emit counter past fill count")
  `ASSERT_CLK(a_fill_grows, clk, rst, in_pop |=> ((fill >= $past(fill)) && (fill != '0)), "fill count shrank on insert")

endmodule

// ===== rtl/top_k_smallest_ranker_top.sv =====
// ----------------------------------------------------------------------------
// top_k_smallest_ranker_top
// Keeps the TABLE_DEPTH smallest scores with their tags and lists them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive score and tag with push; the request is taken on a
//   rising edge with push high and full low. A two-entry queue holds requests
//   while the table is busy.
//   Result channel: while empty is low the oldest result sits on rank,
//   entry_score_out, entry_tag_out and last; pop takes it. After every request
//   the full current list comes out in rank order, last high on its final
//   entry.
//   Sequence: each request is first inserted, then every stored entry is
//   emitted in rank order, up to TABLE_DEPTH entries. The emit sequencer does
//   one table read per cycle while the result queue is not full.
//   Reset (rst, synchronous) empties both queues and the table.
//   If the receiver stalls, the result queue fills, the sequencer holds, and
//   the input queue fills until full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module top_k_smallest_ranker_top
  import tks_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [SCORE_W-1:0] score,
  input  logic [TAG_W-1:0]   tag,
  output logic               empty,
  input  logic               pop,
  output logic [RANK_W-1:0]  rank,
  output logic [SCORE_W-1:0] entry_score_out,
  output logic [TAG_W-1:0]   entry_tag_out,
  output logic               last
);

  item_t   in_wr;
  item_t   in_rd;
  logic    in_empty;
  logic    in_pop;
  result_t res_wr;
  result_t res_rd;
  logic    res_full;
  logic    res_push;

  assign in_wr.score = score;
  assign in_wr.tag   = tag;

  // Queue incoming requests
  tks_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_wr),
    .full  (full),
    .pop   (in_pop),
    .rdata (in_rd),
    .empty (in_empty)
  );

  // Insert and emit
  tks_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_rd),
    .in_empty (in_empty),
    .in_pop   (in_pop),
    .res      (res_wr),
    .out_full (res_full),
    .out_push (res_push)
  );

  // Buffer results toward the receiver
  tks_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wr),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rd),
    .empty (empty)
  );

  assign rank            = res_rd.rank;
  assign entry_score_out = res_rd.score;
  assign entry_tag_out   = res_rd.tag;
  assign last            = res_rd.last;

endmodule

// ===== sim/rank_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rank_list_checker
// Watches both queue channels of the ranker, keeps its own copy of the
// top-k table, and compares every popped entry with the list it predicts.
// ----------------------------------------------------------------------------
module rank_list_checker
  import tks_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [SCORE_W-1:0] score,
  input  logic [TAG_W-1:0]   tag,
  input  logic               empty,
  input  logic               pop,
  input  logic [RANK_W-1:0]  rank,
  input  logic [SCORE_W-1:0] entry_score_out,
  input  logic [TAG_W-1:0]   entry_tag_out,
  input  logic               last,
  output int                 mismatch_count,
  output int                 entries_due
);

  logic [SCORE_W-1:0] table_score [TABLE_DEPTH];
  logic [TAG_W-1:0]   table_tag   [TABLE_DEPTH];
  int unsigned        table_fill;
  result_t            expected_entries [$];

  initial mismatch_count = 0;

  assign entries_due = expected_entries.size();

  // Insert one request into the predicted table, then queue the whole list
  task automatic insert_entry(input logic [SCORE_W-1:0] new_score,
                              input logic [TAG_W-1:0] new_tag);
    int unsigned pos;
    result_t     entry;
    pos = 0;
    while (pos < table_fill && !(new_score < table_score[pos]))
      pos++;
    if (pos < TABLE_DEPTH) begin
      for (int j = TABLE_DEPTH - 1; j > int'(pos); j--) begin
        table_score[j] = table_score[j-1];
        table_tag[j]   = table_tag[j-1];
      end
      table_score[pos] = new_score;
      table_tag[pos]   = new_tag;
      if (table_fill < TABLE_DEPTH)
        table_fill++;
    end
    for (int unsigned k = 0; k < table_fill; k++) begin
      entry.rank  = k[RANK_W-1:0];
      entry.score = table_score[k];
      entry.tag   = table_tag[k];
      entry.last  = (k + 1 == table_fill);
      expected_entries.push_back(entry);
    end
  endtask

  // Compare each popped entry with the oldest prediction
  task automatic check_entry();
    result_t want;
    if (expected_entries.size() == 0) begin
      $error("unexpected entry: rank %0d score %0d tag %0d last %0b",
             rank, entry_score_out, entry_tag_out, last);
      mismatch_count++;
    end else begin
      want = expected_entries.pop_front();
      if (rank !== want.rank) begin
        $error("rank: expected %0d, actual %0d", want.rank, rank);
        mismatch_count++;
      end
      if (entry_score_out !== want.score) begin
        $error("entry_score_out: expected %0d, actual %0d", want.score, entry_score_out);
        mismatch_count++;
      end
      if (entry_tag_out !== want.tag) begin
        $error("entry_tag_out: expected %0d, actual %0d", want.tag, entry_tag_out);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        mismatch_count++;
      end
    end
  endtask

  // Sample both channels on each rising edge
  always @(posedge clk) begin
    if (rst) begin
      table_fill = 0;
      expected_entries.delete();
    end else begin
      if (pop && !empty)
        check_entry();
      if (push && !full)
        insert_entry(score, tag);
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives score/tag requests into the top-k ranker with random gaps and
// receiver stalls, and reports the verdict from the list checker.
// ----------------------------------------------------------------------------
module tb_top
  import tks_pkg::*;
;

  localparam int unsigned TABLE_DEPTH   = 5;
  localparam int          RANDOM_ITEMS  = 250;
  localparam int          QUIET_ITEMS   = 40;
  localparam int          LONG_HOLD     = 80;
  localparam int          IDLE_LIMIT    = 3000;
  localparam int          DRAIN_CYCLES  = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [SCORE_W-1:0] score = '0;
  logic [TAG_W-1:0]   tag = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [RANK_W-1:0]  rank;
  logic [SCORE_W-1:0] entry_score_out;
  logic [TAG_W-1:0]   entry_tag_out;
  logic               last;

  int                 mismatch_count;
  int                 entries_due;
  bit                 quiet = 1'b0;
  bit                 hold_req = 1'b0;
  int                 idle_cycles = 0;

  top_k_smallest_ranker_top #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .score           (score),
    .tag             (tag),
    .empty           (empty),
    .pop             (pop),
    .rank            (rank),
    .entry_score_out (entry_score_out),
    .entry_tag_out   (entry_tag_out),
    .last            (last)
  );

  rank_list_checker #(.TABLE_DEPTH(TABLE_DEPTH)) i_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .score           (score),
    .tag             (tag),
    .empty           (empty),
    .pop             (pop),
    .rank            (rank),
    .entry_score_out (entry_score_out),
    .entry_tag_out   (entry_tag_out),
    .last            (last),
    .mismatch_count  (mismatch_count),
    .entries_due     (entries_due)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [SCORE_W-1:0] s, input logic [TAG_W-1:0] t);
    push  <= 1'b1;
    score <= s;
    tag   <= t;
    @(posedge clk);
    while (full)
      @(posedge clk);
  endtask

  // Now and then drop push for a random idle burst
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Receiver: random short stalls, one long hold-off on request
  initial begin : receiver
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (hold_req && !hold_done) begin
        pop <= 1'b0;
        stall_left = LONG_HOLD - 1;
        hold_done  = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict
  initial begin : sender
    int                 base;
    int                 mode;
    logic [SCORE_W-1:0] prev_score;
    logic [SCORE_W-1:0] s;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: max score into empty table, ties at max, fill the table
    send_request(16'hFFFF, 16'h0000); maybe_idle();
    send_request(16'hFFFF, 16'hFFFF); maybe_idle();
    send_request(16'd40000, 16'h1111); maybe_idle();
    send_request(16'd50000, 16'h2222); maybe_idle();
    send_request(16'd30000, 16'h3333); maybe_idle();
    // Full table, score equal to the last entry: not stored
    send_request(16'hFFFF, 16'h4444); maybe_idle();
    // Full table, score below the last entry: stored, last drops; then equal: not stored
    send_request(16'hFFFE, 16'h5555); maybe_idle();
    send_request(16'hFFFF, 16'h6666); maybe_idle();
    // Tie in the middle goes after the stored equal score
    send_request(16'd40000, 16'hAAAA); maybe_idle();
    // New best at the front, then zero score
    send_request(16'd1000, 16'h5A5A); maybe_idle();
    send_request(16'd0, 16'hA5A5); maybe_idle();
    // Tie at the front, then exact tie with the last entry
    send_request(16'd0, 16'h0F0F); maybe_idle();
    send_request(16'd40000, 16'hF0F0); maybe_idle();
    send_request(16'd30000, 16'h7FFF); maybe_idle();
    send_request(16'd39999, 16'h8000); maybe_idle();

    // Random: a descending score window keeps new entries landing in the table
    base       = 39000;
    prev_score = 16'd39999;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS)
        quiet = 1'b1;
      if (n == 100)
        hold_req = 1'b1;
      // Pause the sender until every list has been drained
      if (n == 170) begin
        push <= 1'b0;
        @(posedge clk);
        while (entries_due != 0)
          @(posedge clk);
      end
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin
          s = SCORE_W'($urandom_range(0, 65535));
        end
        1: begin
          s = prev_score;
        end
        2: begin
          s = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        end
        default: begin
          s = (base > 300) ? SCORE_W'(base - int'($urandom_range(0, 300)))
                           : SCORE_W'($urandom_range(0, base));
        end
      endcase
      if (base > 200)
        base = base - int'($urandom_range(80, 200));
      prev_score = s;
      send_request(s, TAG_W'($urandom_range(0, 65535)));
      maybe_idle();
    end
    push <= 1'b0;

    // Drain, then allow the pipeline to settle
    @(posedge clk);
    while (entries_due != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
